// File: rtl/core/firewall_rule_range_table_top_macros.svh
// Assertion macros for the firewall rule table.
`ifndef FIREWALL_RULE_RANGE_TABLE_TOP_MACROS_SVH
`define FIREWALL_RULE_RANGE_TABLE_TOP_MACROS_SVH
`ifndef SYNTH
`define FRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FRT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FRT_ASSERT(label, clk, rst_n, prop, msg)
`define FRT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/core/frt_pkg.sv
// ----------------------------------------------------------------------------
// Firewall rule table package
// Types, constants and codes shared by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int unsigned Rules = 16;
  localparam int unsigned IdxW = $clog2(Rules);
  localparam int unsigned CntW = $clog2(Rules + 1);
  localparam logic [15:0] HitMax = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0, CMD_CHECK = 2'd1, CMD_DELETE = 2'd2, CMD_LIST = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_ADDED = 4'd0, ST_INVALID = 4'd1, ST_FULL = 4'd2, ST_ACCEPTED = 4'd3,
    ST_REJECTED = 4'd4, ST_DELETED = 4'd5, ST_NOTFOUND = 4'd6, ST_EMPTY = 4'd7,
    ST_LISTED = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_RESP, S_LIST, S_LWAIT
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic        is_range;
    logic [15:0] port_low;
    logic [15:0] port_high;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] rule_addr_low;
    logic [31:0] rule_addr_high;
    logic        rule_is_range;
    logic [15:0] rule_port_low;
    logic [15:0] rule_port_high;
    logic [15:0] rule_hits;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr_low;
    logic [31:0] addr_high;
    logic        is_range;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [15:0] hits;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load;      // capture the request
    logic            append;    // write the request as a new entry
    logic            step;      // one walk step over the read entry
    logic [IdxW-1:0] rd_idx;    // entry read address
    logic            rd_en;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic            range_bad;
    logic            any_hit;
    logic [CntW-1:0] count;
    logic [CntW-1:0] wr_ptr;
  } stat_t;

endpackage

// File: rtl/core/firewall_rule_range_table_top.sv
// ----------------------------------------------------------------------------
// Firewall rule range table, top level
// Controller and datapath for a table of address and port rules.
// ----------------------------------------------------------------------------
// Use: one command item enters on the in channel (valid/ready) and gives one
// or more result items on the out channel (valid/ready); the final one of a
// command has last set. Add loads its result into the output register from
// the response state once that register is free. Check and delete walk the
// entry memory one entry a cycle through its single read port, then give
// their result from the response state; an empty table or an invalid range
// delete ends the walk at once. List gives its first entry from the wait state
// and then one entry a cycle while the receiver takes them. The block takes
// one command at a time and accepts the next the cycle after the final result
// is loaded into the output register. Reset empties the table; entry contents
// are undefined until added. A stalled receiver holds the output register; the
// listing and a waiting result wait with it, losing nothing, but a walk runs on.
// ----------------------------------------------------------------------------
`include "firewall_rule_range_table_top_macros.svh"
module firewall_rule_range_table_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  frt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output frt_pkg::out_item_t out_data_o
);
  frt_pkg::ctrl_t  ctrl;
  frt_pkg::stat_t  stat;
  frt_pkg::entry_t rd_entry;

  frt_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (in_data_i),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .rd_entry_o(rd_entry)
  );

  frt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_cmd_i   (in_data_i.command),
    .stat_i     (stat),
    .rd_entry_i (rd_entry),
    .ctrl_o     (ctrl),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // The table never holds more entries than it has room for.
  `FRT_ASSERT(a_count_max, clk_i, rst_ni, stat.count <= frt_pkg::CntW'(frt_pkg::Rules), "count overflow")
  // An append only happens with room left.
  `FRT_ASSERT(a_append_room, clk_i, rst_ni, !ctrl.append || stat.count < frt_pkg::CntW'(frt_pkg::Rules), "append when full")
  // A stalled result holds.
  `FRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")
endmodule

// File: rtl/core/frt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: rtl/core/frt_datapath.sv
// ----------------------------------------------------------------------------
// Firewall rule table datapath
// Holds the request, the entry memory and the entry count. A walk reads the
// entries one a cycle, updates hit counts and compacts the table on delete.
// ----------------------------------------------------------------------------
module frt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  frt_pkg::in_item_t    req_i,
  input  frt_pkg::ctrl_t       ctrl_i,
  output frt_pkg::stat_t       stat_o,
  output frt_pkg::entry_t      rd_entry_o
);
  frt_pkg::in_item_t            req_q;
  logic [frt_pkg::CntW-1:0]     count_q, count_d;
  logic [frt_pkg::CntW-1:0]     wp_q, wp_d;
  logic                         any_q, any_d;
  logic                         we;
  logic [frt_pkg::IdxW-1:0]     waddr;
  frt_pkg::entry_t              wdata, rdata, new_e, upd_e;
  logic                         hit;

  frt_ram #(.Width($bits(frt_pkg::entry_t)), .Depth(frt_pkg::Rules)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.rd_en),
    .raddr_i(ctrl_i.rd_idx),
    .rdata_o(rdata)
  );

  // Entry built from the request for an append.
  always_comb begin
    new_e.addr_low  = req_q.addr_low;
    new_e.addr_high = req_q.is_range ? req_q.addr_high : 32'd0;
    new_e.is_range  = req_q.is_range;
    new_e.port_low  = req_q.port_low;
    new_e.port_high = req_q.is_range ? req_q.port_high : 16'd0;
    new_e.hits      = 16'd0;
  end

  // Match the entry just read against the request.
  always_comb begin
    hit = 1'b0;
    upd_e = rdata;
    if (req_q.command == frt_pkg::CMD_CHECK) begin
      if (rdata.is_range) begin
        hit = (rdata.addr_low <= req_q.addr_low) && (req_q.addr_low <= rdata.addr_high) &&
              (rdata.port_low <= req_q.port_low) && (req_q.port_low <= rdata.port_high);
      end else begin
        hit = (rdata.addr_low == req_q.addr_low) && (rdata.port_low == req_q.port_low);
      end
      if (hit && rdata.hits != frt_pkg::HitMax) begin
        upd_e.hits = rdata.hits + 16'd1;
      end
    end else if (req_q.is_range) begin
      hit = rdata.is_range && rdata.addr_low == req_q.addr_low &&
            rdata.addr_high == req_q.addr_high && rdata.port_low == req_q.port_low &&
            rdata.port_high == req_q.port_high;
    end else begin
      hit = !rdata.is_range && rdata.addr_low == req_q.addr_low &&
            rdata.port_low == req_q.port_low;
    end
  end

  // Memory write, write pointer and count updates.
  always_comb begin
    we      = 1'b0;
    waddr   = wp_q[frt_pkg::IdxW-1:0];
    wdata   = upd_e;
    count_d = count_q;
    wp_d    = wp_q;
    any_d   = any_q;
    if (ctrl_i.load) begin
      wp_d  = '0;
      any_d = 1'b0;
    end else if (ctrl_i.append) begin
      we      = 1'b1;
      waddr   = count_q[frt_pkg::IdxW-1:0];
      wdata   = new_e;
      count_d = count_q + 1'b1;
    end else if (ctrl_i.step) begin
      if (hit) begin
        any_d = 1'b1;
      end
      if (req_q.command == frt_pkg::CMD_CHECK) begin
        we   = 1'b1;
        wp_d = wp_q + 1'b1;
      end else if (hit) begin
        count_d = count_q - 1'b1;
      end else begin
        we   = 1'b1;
        wp_d = wp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      wp_q    <= '0;
      any_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      wp_q    <= wp_d;
      any_q   <= any_d;
    end
  end

  assign stat_o.range_bad = req_q.is_range && !((req_q.addr_low <= req_q.addr_high) &&
                            (req_q.port_low < req_q.port_high));
  assign stat_o.any_hit   = any_q;
  assign stat_o.count     = count_q;
  assign stat_o.wr_ptr    = wp_q;
  assign rd_entry_o       = rdata;
endmodule

// File: rtl/core/frt_ctrl.sv
// ----------------------------------------------------------------------------
// Firewall rule table controller
// Sequences add, check, delete and list, and drives the output register.
// ----------------------------------------------------------------------------
module frt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_cmd_i,
  input  frt_pkg::stat_t       stat_i,
  input  frt_pkg::entry_t      rd_entry_i,
  output frt_pkg::ctrl_t       ctrl_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output frt_pkg::out_item_t   out_data_o
);
  frt_pkg::state_e           state_q, state_d;
  logic [1:0]                cmd_q;
  logic [frt_pkg::CntW-1:0]  idx_q, idx_d, n_q, n_d;
  logic                      rd_pend_q, rd_pend_d;
  logic                      ov_q, ov_d;
  frt_pkg::out_item_t        od_q, od_d;
  logic                      free;

  assign free = !ov_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    n_d       = n_q;
    rd_pend_d = 1'b0;
    ov_d      = ov_q && !out_ready_i;
    od_d      = od_q;
    ctrl_o    = '0;
    ctrl_o.rd_idx = idx_q[frt_pkg::IdxW-1:0];
    in_ready_o = 1'b0;
    case (state_q)
      frt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          idx_d = '0;
          // The walk length is fixed here, as a delete shrinks the count as it goes.
          n_d = stat_i.count;
          state_d = frt_pkg::S_RESP;
          if (in_cmd_i == frt_pkg::CMD_CHECK || in_cmd_i == frt_pkg::CMD_DELETE) begin
            state_d = frt_pkg::S_WALK;
          end else if (in_cmd_i == frt_pkg::CMD_LIST) begin
            state_d = frt_pkg::S_LIST;
          end
        end
      end
      // One entry read a cycle; the step lands the cycle after the read.
      frt_pkg::S_WALK: begin
        if (rd_pend_q) begin
          ctrl_o.step = 1'b1;
        end
        if (cmd_q == frt_pkg::CMD_DELETE && stat_i.range_bad) begin
          state_d = frt_pkg::S_RESP;
        end else if (idx_q < n_q) begin
          ctrl_o.rd_en = 1'b1;
          rd_pend_d = 1'b1;
          idx_d = idx_q + 1'b1;
        end else if (!rd_pend_q) begin
          state_d = frt_pkg::S_RESP;
        end
      end
      frt_pkg::S_RESP: begin
        if (free) begin
          od_d = '0;
          od_d.last = 1'b1;
          case (cmd_q)
            frt_pkg::CMD_ADD: begin
              if (stat_i.range_bad) od_d.status = frt_pkg::ST_INVALID;
              else if (stat_i.count >= frt_pkg::CntW'(frt_pkg::Rules))
                od_d.status = frt_pkg::ST_FULL;
              else begin
                od_d.status = frt_pkg::ST_ADDED;
                ctrl_o.append = 1'b1;
              end
            end
            frt_pkg::CMD_CHECK: od_d.status = stat_i.any_hit ? frt_pkg::ST_ACCEPTED
                                                               : frt_pkg::ST_REJECTED;
            frt_pkg::CMD_DELETE: begin
              if (stat_i.range_bad) od_d.status = frt_pkg::ST_INVALID;
              else od_d.status = stat_i.any_hit ? frt_pkg::ST_DELETED
                                                : frt_pkg::ST_NOTFOUND;
            end
            default: od_d.status = frt_pkg::ST_EMPTY;
          endcase
          ov_d = 1'b1;
          state_d = frt_pkg::S_IDLE;
        end
      end
      frt_pkg::S_LIST: begin
        n_d = stat_i.count;
        if (stat_i.count == '0) begin
          state_d = frt_pkg::S_RESP;
        end else begin
          ctrl_o.rd_en = 1'b1;
          state_d = frt_pkg::S_LWAIT;
        end
      end
      // Entry at idx_q is in the read register; emit it when the output frees.
      frt_pkg::S_LWAIT: begin
        if (free) begin
          od_d.status         = frt_pkg::ST_LISTED;
          od_d.rule_addr_low  = rd_entry_i.addr_low;
          od_d.rule_addr_high = rd_entry_i.addr_high;
          od_d.rule_is_range  = rd_entry_i.is_range;
          od_d.rule_port_low  = rd_entry_i.port_low;
          od_d.rule_port_high = rd_entry_i.port_high;
          od_d.rule_hits      = rd_entry_i.hits;
          od_d.last           = (idx_q + 1'b1 == n_q);
          ov_d = 1'b1;
          idx_d = idx_q + 1'b1;
          if (idx_q + 1'b1 == n_q) begin
            state_d = frt_pkg::S_IDLE;
          end else begin
            ctrl_o.rd_en  = 1'b1;
            ctrl_o.rd_idx = idx_d[frt_pkg::IdxW-1:0];
          end
        end
      end
      default: state_d = frt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= frt_pkg::S_IDLE;
      idx_q     <= '0;
      n_q       <= '0;
      rd_pend_q <= 1'b0;
      ov_q      <= 1'b0;
      cmd_q     <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      n_q       <= n_d;
      rd_pend_q <= rd_pend_d;
      ov_q      <= ov_d;
      if (ctrl_o.load) begin
        cmd_q <= in_cmd_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
endmodule
